/* design/ect_pkg.sv */
package ect_pkg;

	localparam int MaxPoints = 16;
	localparam int CoordBits = 16;
	localparam int IdxBits = 4;

	// sequencer states
	localparam logic [3:0] ST_LOAD  = 4'd0;
	localparam logic [3:0] ST_AREA  = 4'd1;
	localparam logic [3:0] ST_ORDER = 4'd2;
	localparam logic [3:0] ST_EAR   = 4'd3;
	localparam logic [3:0] ST_TEST  = 4'd4;
	localparam logic [3:0] ST_EMIT  = 4'd5;
	localparam logic [3:0] ST_SHIFT = 4'd6;
	localparam logic [3:0] ST_FAN   = 4'd7;
	localparam logic [3:0] ST_LAST  = 4'd8;
	localparam logic [3:0] ST_SHORT = 4'd9;
	localparam logic [3:0] ST_RD    = 4'd10;
	localparam logic [3:0] ST_RD2   = 4'd11;

	// control for the shared cross-product unit
	typedef struct packed {
		logic        go;
		logic        acc;
		logic        clr;
	} cross_ctl_t;

endpackage

/* design/ect_cross.sv */
// Shared orientation unit: registered sign of (b-a) x (c-a), plus an area accumulator
module ect_cross
	import ect_pkg::*;
#(
	parameter int COORD_BITS = CoordBits
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cross_ctl_t                   ctl,
	input  logic signed [COORD_BITS-1:0] ax,
	input  logic signed [COORD_BITS-1:0] ay,
	input  logic signed [COORD_BITS-1:0] bx,
	input  logic signed [COORD_BITS-1:0] by,
	input  logic signed [COORD_BITS-1:0] cx,
	input  logic signed [COORD_BITS-1:0] cy,
	output logic                         done,
	output logic [1:0]                   turn_sign,
	output logic                         area_neg
);
	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * DW;
	localparam int AW = PW + 6;

	logic signed [PW-1:0] p1_s1, p2_s1;
	logic                 acc_s1, v_s1;
	logic signed [AW-1:0] area_q;
	logic signed [PW:0]   diff;
	logic signed [DW-1:0] ux, uy, wx, wy;

	assign ux = DW'(bx) - DW'(ax);
	assign wy = DW'(cy) - DW'(ay);
	assign wx = DW'(cx) - DW'(ax);
	assign uy = DW'(by) - DW'(ay);

	// stage one: two products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= ctl.go;
		end
	end
	always_ff @(posedge clk) begin
		p1_s1  <= ux * wy;
		p2_s1  <= wx * uy;
		acc_s1 <= ctl.acc;
	end

	assign diff = (PW+1)'(p1_s1) - (PW+1)'(p2_s1);

	// stage two: sign and area accumulation; cleared while loading
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done      <= 1'b0;
			turn_sign <= 2'b00;
			area_q    <= '0;
		end else begin
			done <= v_s1;
			if (v_s1) begin
				turn_sign <= diff[PW] ? 2'b11 : ((diff == '0) ? 2'b00 : 2'b01);
				if (acc_s1) area_q <= area_q + AW'(diff);
			end else if (ctl.clr) begin
				area_q <= '0;
			end
		end
	end
	assign area_neg = area_q[AW-1];
endmodule

/* design/ear_clip_triangulator.sv */
// Ear-clipping triangulator.
// Loading: one vertex item per cycle, no result until the last vertex.
// Triangulation: area pass, then order build, then ear search, with every orientation
// test run in the shared cross unit, one test at a time.
// The block is not ready from the last vertex until the final result item is accepted.
// Reset (arst_n low) clears the point count and overflow flag and returns to loading.
module ear_clip_triangulator
	import ect_pkg::*;
#(
	parameter int MAX_POINTS = MaxPoints,
	parameter int COORD_BITS = CoordBits
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic signed [15:0]    point_x,
	input  logic signed [15:0]    point_y,
	input  logic                  last_point,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [IdxBits-1:0]    corner_a,
	output logic [IdxBits-1:0]    corner_b,
	output logic [IdxBits-1:0]    corner_c,
	output logic                  no_triangle,
	output logic                  overflow,
	output logic                  last_triangle
);
	localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);

	logic signed [COORD_BITS-1:0] xs_q [MAX_POINTS];
	logic signed [COORD_BITS-1:0] ys_q [MAX_POINTS];
	logic [IW-1:0] ord_q [MAX_POINTS];

	logic [3:0]    state_q;
	logic [CW-1:0] cnt_q, m_q;
	logic          ovf_q;
	logic [IW-1:0] i_q, j_q, k_q;
	logic [1:0]    ph_q;
	logic [1:0]    d_q [2];
	logic [IW-1:0] ta_q, tb_q, tc_q, tp_q;

	cross_ctl_t ctl;
	logic       xdone, area_neg;
	logic [1:0] tsgn;
	logic signed [COORD_BITS-1:0] ax, ay, bx, by, cx, cy;

	logic in_acc, out_acc;
	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;
	assign in_ready = (state_q == ST_LOAD);

	// modular neighbours within remaining list
	function automatic logic [IW-1:0] nxt(input logic [IW-1:0] i, input logic [CW-1:0] m);
		nxt = (CW'(i) + 1'b1 == m) ? '0 : IW'(CW'(i) + 1'b1);
	endfunction
	function automatic logic [IW-1:0] prv(input logic [IW-1:0] i, input logic [CW-1:0] m);
		prv = (i == '0) ? IW'(m - 1'b1) : i - 1'b1;
	endfunction

	logic [IW-1:0] ip, inx;
	assign ip  = prv(i_q, m_q);
	assign inx = nxt(i_q, m_q);

	// operand select for the cross unit
	logic [IW-1:0] oa, ob, oc;
	always_comb begin
		oa = ta_q; ob = tb_q; oc = tc_q;
		if (state_q == ST_AREA) begin
			oa = '0; ob = i_q; oc = IW'(CW'(i_q) + 1'b1);
		end else if (state_q == ST_TEST) begin
			case (ph_q)
				2'd0:    begin oa = ta_q; ob = tb_q; oc = tp_q; end
				2'd1:    begin oa = tb_q; ob = tc_q; oc = tp_q; end
				default: begin oa = tc_q; ob = ta_q; oc = tp_q; end
			endcase
		end
	end
	assign ax = xs_q[oa]; assign ay = ys_q[oa];
	assign bx = xs_q[ob]; assign by = ys_q[ob];
	assign cx = xs_q[oc]; assign cy = ys_q[oc];

	// neighbours of the candidate are not tested against its triangle
	logic j_skip;
	assign j_skip = (j_q == ip) || (j_q == i_q) || (j_q == inx);

	logic busy_q;
	always_comb begin
		ctl.go  = !busy_q && ((state_q == ST_AREA) || (state_q == ST_EAR) ||
			((state_q == ST_TEST) && !j_skip));
		ctl.acc = (state_q == ST_AREA);
		ctl.clr = (state_q == ST_LOAD);
	end

	ect_cross #(.COORD_BITS(COORD_BITS)) u_cross (
		.clk, .arst_n, .ctl, .ax, .ay, .bx, .by, .cx, .cy,
		.done(xdone), .turn_sign(tsgn), .area_neg
	);

	// vertex store writes
	always_ff @(posedge clk) begin
		if (in_acc && (cnt_q < CW'(MAX_POINTS))) begin
			xs_q[cnt_q[IW-1:0]] <= COORD_BITS'($unsigned(point_x));
			ys_q[cnt_q[IW-1:0]] <= COORD_BITS'($unsigned(point_y));
		end
	end

	// remaining order: build and one-entry-per-cycle removal
	always_ff @(posedge clk) begin
		if (state_q == ST_ORDER)
			ord_q[i_q] <= area_neg ? IW'(cnt_q - 1'b1 - CW'(i_q)) : i_q;
		else if (state_q == ST_SHIFT && CW'(k_q) + 1'b1 < m_q)
			ord_q[k_q] <= ord_q[IW'(CW'(k_q) + 1'b1)];
	end

	// result register loads; valid drops once the item is taken
	logic res_load;
	assign res_load = (state_q == ST_SHORT) ||
		(((state_q == ST_EMIT) || (state_q == ST_FAN) || (state_q == ST_LAST)) &&
		 (!out_valid || out_acc));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (res_load) begin
			out_valid <= 1'b1;
		end else if (out_acc) begin
			out_valid <= 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			cnt_q     <= '0;
			ovf_q     <= 1'b0;
			busy_q    <= 1'b0;
			i_q <= '0; j_q <= '0; k_q <= '0; ph_q <= '0; m_q <= '0;
			ta_q <= '0; tb_q <= '0; tc_q <= '0; tp_q <= '0;
			corner_a <= '0; corner_b <= '0; corner_c <= '0;
			no_triangle <= 1'b0; overflow <= 1'b0; last_triangle <= 1'b0;
		end else begin
			if (xdone) busy_q <= 1'b0;
			else if (ctl.go) busy_q <= 1'b1;
			case (state_q)
				ST_LOAD: if (in_acc) begin
					if (cnt_q < CW'(MAX_POINTS)) cnt_q <= cnt_q + 1'b1;
					else ovf_q <= 1'b1;
					if (last_point) begin
						i_q <= IW'(1);
						if ((cnt_q < CW'(MAX_POINTS) ? cnt_q + 1'b1 : cnt_q) < CW'(3))
							state_q <= ST_SHORT;
						else
							state_q <= ST_AREA;
					end
				end
				ST_SHORT: begin
					corner_a <= '0; corner_b <= '0; corner_c <= '0;
					no_triangle <= 1'b1; overflow <= ovf_q; last_triangle <= 1'b1;
					state_q <= ST_RD2;
				end
				ST_AREA: if (xdone) begin
					if (CW'(i_q) + 2'd2 >= cnt_q) begin
						i_q <= '0; state_q <= ST_ORDER;
					end else i_q <= i_q + 1'b1;
				end
				ST_ORDER: begin
					if (CW'(i_q) + 1'b1 == cnt_q) begin
						m_q <= cnt_q; i_q <= '0; state_q <= ST_RD;
					end else i_q <= i_q + 1'b1;
				end
				ST_RD: begin
					// pick candidate ear from current index, or the final triangle when three remain
					if (m_q <= CW'(3)) begin
						ta_q <= ord_q[0]; tb_q <= ord_q[1]; tc_q <= ord_q[2];
						state_q <= ST_LAST;
					end else begin
						ta_q <= ord_q[ip]; tb_q <= ord_q[i_q]; tc_q <= ord_q[inx];
						state_q <= ST_EAR;
					end
				end
				ST_EAR: if (xdone) begin
					if (tsgn == 2'b01) begin
						j_q <= '0; ph_q <= '0;
						tp_q <= ord_q[0];
						state_q <= ST_TEST;
					end else if (CW'(i_q) + 1'b1 == m_q) begin
						k_q <= IW'(1); state_q <= ST_FAN;
					end else begin
						i_q <= i_q + 1'b1; state_q <= ST_RD;
					end
				end
				ST_TEST: begin
					if (j_skip && !busy_q) begin
						if (CW'(j_q) + 1'b1 == m_q) state_q <= ST_EMIT;
						else begin j_q <= j_q + 1'b1; tp_q <= ord_q[IW'(CW'(j_q) + 1'b1)]; end
					end else if (xdone) begin
						if (ph_q != 2'd2) begin
							d_q[ph_q[0]] <= tsgn;
							ph_q <= ph_q + 1'b1;
						end else begin
							ph_q <= '0;
							if (!(((d_q[0] == 2'b11) || (d_q[1] == 2'b11) || (tsgn == 2'b11)) &&
							      ((d_q[0] == 2'b01) || (d_q[1] == 2'b01) || (tsgn == 2'b01)))) begin
								// point inside or on an edge: not an ear
								if (CW'(i_q) + 1'b1 == m_q) begin
									k_q <= IW'(1); state_q <= ST_FAN;
								end else begin
									i_q <= i_q + 1'b1; state_q <= ST_RD;
								end
							end else if (CW'(j_q) + 1'b1 == m_q) state_q <= ST_EMIT;
							else begin
								j_q <= j_q + 1'b1; tp_q <= ord_q[IW'(CW'(j_q) + 1'b1)];
							end
						end
					end
				end
				ST_EMIT: if (res_load) begin
					corner_a <= 4'(ta_q); corner_b <= 4'(tb_q); corner_c <= 4'(tc_q);
					no_triangle <= 1'b0; overflow <= ovf_q; last_triangle <= 1'b0;
					k_q <= i_q; state_q <= ST_SHIFT;
				end
				ST_SHIFT: begin
					if (CW'(k_q) + 1'b1 >= m_q) begin
						m_q <= m_q - 1'b1; i_q <= '0; state_q <= ST_RD;
					end else k_q <= k_q + 1'b1;
				end
				ST_FAN: if (res_load) begin
					corner_a <= 4'(ord_q[0]); corner_b <= 4'(ord_q[k_q]);
					corner_c <= 4'(ord_q[IW'(CW'(k_q) + 1'b1)]);
					no_triangle <= 1'b0; overflow <= ovf_q;
					last_triangle <= (CW'(k_q) + 2'd2 == m_q);
					if (CW'(k_q) + 2'd2 == m_q) state_q <= ST_RD2;
					else k_q <= k_q + 1'b1;
				end
				ST_LAST: if (res_load) begin
					corner_a <= 4'(ta_q); corner_b <= 4'(tb_q); corner_c <= 4'(tc_q);
					no_triangle <= 1'b0; overflow <= ovf_q; last_triangle <= 1'b1;
					state_q <= ST_RD2;
				end
				ST_RD2: if (out_acc) begin
					cnt_q <= '0; ovf_q <= 1'b0; state_q <= ST_LOAD;
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// checks
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_LOAD) |-> !in_ready) else $error("ready while busy");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_POINTS)) else $error("count overrun");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && last_triangle) |=> (state_q == ST_LOAD)) else $error("run not closed");
endmodule

/* tb/ear_clip_triangulator_test.sv */
`timescale 1ns / 100ps

module ear_clip_triangulator_test;
	import ect_pkg::*;

	localparam int CycleLimit = 3000000;

	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic               last;
		logic               hold;
		int                 wait_for;
	} vertex_item_t;

	typedef struct {
		logic [IdxBits-1:0] a;
		logic [IdxBits-1:0] b;
		logic [IdxBits-1:0] c;
		logic               nt;
		logic               ov;
		logic               lt;
	} triangle_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid;
	logic in_ready;
	logic signed [15:0] point_x;
	logic signed [15:0] point_y;
	logic last_point;
	logic out_valid;
	logic out_ready;
	logic [IdxBits-1:0] corner_a;
	logic [IdxBits-1:0] corner_b;
	logic [IdxBits-1:0] corner_c;
	logic no_triangle;
	logic overflow;
	logic last_triangle;

	vertex_item_t pending_vertices[$];
	triangle_t    expected_triangles[$];
	int           error_count = 0;
	int           cycle_count = 0;
	int           send_gap = 0;
	int           recv_gap = 0;
	int           predicted_total = 0;
	int           received_total = 0;
	bit           quiet = 0;

	// predictor copy of the vertex store
	longint vx[MaxPoints];
	longint vy[MaxPoints];
	int     stored = 0;
	bit     dropped = 0;

	ear_clip_triangulator u_top (.*);

	// clock
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic int turn_sign(int ia, int ib, int ic);
		longint cr;
		cr = (vx[ib] - vx[ia]) * (vy[ic] - vy[ia]) - (vx[ic] - vx[ia]) * (vy[ib] - vy[ia]);
		return (cr > 0) ? 1 : ((cr < 0) ? -1 : 0);
	endfunction

	function automatic bit covers(int p, int a, int b, int c);
		int d1, d2, d3;
		d1 = turn_sign(a, b, p);
		d2 = turn_sign(b, c, p);
		d3 = turn_sign(c, a, p);
		return !((d1 < 0 || d2 < 0 || d3 < 0) && (d1 > 0 || d2 > 0 || d3 > 0));
	endfunction

	function automatic void push_triangle(int a, int b, int c, bit nt);
		triangle_t t;
		t.a = a[IdxBits-1:0];
		t.b = b[IdxBits-1:0];
		t.c = c[IdxBits-1:0];
		t.nt = nt;
		t.ov = dropped;
		t.lt = 1'b0;
		expected_triangles.insert(expected_triangles.size(), t);
		predicted_total++;
	endfunction

	// clip ears from the stored polygon and queue the triangles
	function automatic void clip_polygon();
		int ord[MaxPoints];
		int m, ip, inx;
		longint area;
		bit clipped, ok;
		if (stored < 3) begin
			push_triangle(0, 0, 0, 1'b1);
		end else begin
			area = 0;
			for (int i = 1; i + 1 < stored; i++)
				area += (vx[i] - vx[0]) * (vy[i+1] - vy[0]) - (vx[i+1] - vx[0]) * (vy[i] - vy[0]);
			for (int i = 0; i < stored; i++)
				ord[i] = (area >= 0) ? i : stored - 1 - i;
			m = stored;
			while (m > 3) begin
				clipped = 0;
				for (int i = 0; i < m && !clipped; i++) begin
					ip = (i + m - 1) % m;
					inx = (i + 1) % m;
					if (turn_sign(ord[ip], ord[i], ord[inx]) <= 0)
						continue;
					ok = 1;
					for (int j = 0; j < m && ok; j++) begin
						if (j == ip || j == i || j == inx)
							continue;
						if (covers(ord[j], ord[ip], ord[i], ord[inx]))
							ok = 0;
					end
					if (!ok)
						continue;
					push_triangle(ord[ip], ord[i], ord[inx], 1'b0);
					for (int k = i; k < m - 1; k++)
						ord[k] = ord[k+1];
					m--;
					clipped = 1;
				end
				if (!clipped) begin
					for (int j = 1; j + 1 < m; j++)
						push_triangle(ord[0], ord[j], ord[j+1], 1'b0);
					m = 0;
				end
			end
			if (m == 3)
				push_triangle(ord[0], ord[1], ord[2], 1'b0);
		end
		expected_triangles[$].lt = 1'b1;
		stored = 0;
		dropped = 0;
	endfunction

	// queue one vertex and advance the prediction
	task automatic add_vertex(int x, int y, bit last, bit hold = 0);
		vertex_item_t v;
		v.x = x[15:0];
		v.y = y[15:0];
		v.last = last;
		v.hold = hold;
		v.wait_for = predicted_total;
		pending_vertices.insert(pending_vertices.size(), v);
		if (stored < MaxPoints) begin
			vx[stored] = longint'(v.x);
			vy[stored] = longint'(v.y);
			stored++;
		end else begin
			dropped = 1;
		end
		if (last)
			clip_polygon();
	endtask

	// random polygon; size and coordinate span vary
	task automatic add_polygon(int n, int span, bit hold = 0);
		for (int i = 0; i < n; i++)
			add_vertex($urandom_range(0, 2 * span) - span, $urandom_range(0, 2 * span) - span,
				i == n - 1, hold && i == 0);
	endtask

	// driver; a held item waits until every earlier result has come
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			point_x <= '0;
			point_y <= '0;
			last_point <= 1'b0;
			send_gap <= 0;
		end else if (!in_valid || in_ready) begin
			if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_vertices.size() > 0 &&
					(!pending_vertices[0].hold ||
					 received_total >= pending_vertices[0].wait_for)) begin
				in_valid <= 1'b1;
				point_x <= pending_vertices[0].x;
				point_y <= pending_vertices[0].y;
				last_point <= pending_vertices[0].last;
				void'(pending_vertices.pop_front());
				if (!quiet && $urandom_range(0, 5) == 0)
					send_gap <= $urandom_range(1, 8);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		triangle_t t;
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (recv_gap > 0) begin
				out_ready <= 1'b0;
				recv_gap <= recv_gap - 1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				recv_gap <= $urandom_range(0, 7);
			end else begin
				out_ready <= 1'b1;
			end
			if (out_valid && out_ready) begin
				received_total++;
				if (expected_triangles.size() == 0) begin
					$error("unexpected triangle %0d %0d %0d", corner_a, corner_b, corner_c);
					error_count++;
				end else begin
					t = expected_triangles.pop_front();
					if (t.nt !== no_triangle) begin
						$error("no_triangle exp %0d got %0d", t.nt, no_triangle);
						error_count++;
					end
					if (t.a !== corner_a) begin
						$error("corner_a exp %0d got %0d", t.a, corner_a);
						error_count++;
					end
					if (t.b !== corner_b) begin
						$error("corner_b exp %0d got %0d", t.b, corner_b);
						error_count++;
					end
					if (t.c !== corner_c) begin
						$error("corner_c exp %0d got %0d", t.c, corner_c);
						error_count++;
					end
					if (t.ov !== overflow) begin
						$error("overflow exp %0d got %0d", t.ov, overflow);
						error_count++;
					end
					if (t.lt !== last_triangle) begin
						$error("last_triangle exp %0d got %0d", t.lt, last_triangle);
						error_count++;
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int total;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: short polygons
		add_vertex(0, 0, 1);
		add_vertex(5, 5, 0);
		add_vertex(-5, 7, 1);
		// counter-clockwise triangle at the coordinate extremes
		add_vertex(-32768, -32768, 0);
		add_vertex(32767, -32768, 0);
		add_vertex(32767, 32767, 1);
		// clockwise square, reversed order
		add_vertex(0, 0, 0);
		add_vertex(0, 256, 0);
		add_vertex(256, 256, 0);
		add_vertex(256, 0, 1);
		// all collinear: no ear, fan
		add_vertex(0, 0, 0);
		add_vertex(1, 1, 0);
		add_vertex(2, 2, 0);
		add_vertex(3, 3, 1);
		// concave arrow
		add_vertex(0, 0, 0, 1);
		add_vertex(100, 50, 0);
		add_vertex(0, 100, 0);
		add_vertex(30, 50, 1);
		total = 18;

		// overflow: full store, final vertex dropped too
		for (int i = 0; i < 18; i++)
			add_vertex($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
				i == 17);
		total += 18;

		// random polygons
		while (total < 330) begin
			int n, span;
			case ($urandom_range(0, 9))
				0: n = $urandom_range(1, 2);
				1: n = $urandom_range(16, 18);
				default: n = $urandom_range(3, 9);
			endcase
			span = ($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(2, 300);
			if (total > 280)
				quiet = 1;
			add_polygon(n, span, total > 150 && total < 170);
			total += n;
			wait (pending_vertices.size() < 20);
		end

		wait (pending_vertices.size() == 0 && !in_valid);
		wait (expected_triangles.size() == 0);
		repeat (200) @(posedge clk);
		if (error_count == 0 && expected_triangles.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
